>>> hw/rtl/lcgrm_pkg.sv
// Shared definitions for the LCG random number core: generator constants,
// request codes and the divider status type. No dependencies.
`timescale 1ns / 1ps

package lcgrm_pkg;

    localparam logic [31:0] LCG_MUL     = 32'h0019_660D;
    localparam logic [31:0] LCG_ADD     = 32'h3C6E_F35F;
    localparam logic [31:0] LOW31_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] FRAC23_MASK = 32'h007F_FFFF;

    localparam logic [1:0] FUNC_RAW      = 2'd0;
    localparam logic [1:0] FUNC_MODULO   = 2'd1;
    localparam logic [1:0] FUNC_FRACTION = 2'd2;
    localparam logic [1:0] FUNC_LOAD     = 2'd3;

    localparam int DIV_BITS  = 31;
    localparam int CNT_W     = $clog2(DIV_BITS);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> hw/rtl/lcgrm_divider.sv
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// Depends on lcgrm_pkg.
`timescale 1ns / 1ps

module lcgrm_divider (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [30:0]          dividend,
    input  logic [31:0]          divisor,
    output logic [31:0]          remainder,
    output lcgrm_pkg::div_status_t status
);
    import lcgrm_pkg::*;

    logic [31:0]      rem_reg, rem_next;
    logic [30:0]      dvd_reg, dvd_next;
    logic [31:0]      dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;

    assign trial = {rem_reg, dvd_reg[30]};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = 32'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = trial[31:0];
            end
            dvd_next = {dvd_reg[29:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_BITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> hw/rtl/lcg_random_with_modulo_core.sv
// Linear congruential random number core with raw, modulo, fraction and
// seed load requests. Depends on lcgrm_pkg and lcgrm_divider.
`timescale 1ns / 1ps

// Usage: a request transaction on the slave side carries the request code in
// s_tuser and the operand (divisor or new seed) in s_tdata. Each request
// gives exactly one result transaction on the master side, with the number
// in m_tdata and the zero-divisor flag in m_tuser.
// For raw, fraction and zero-divisor modulo requests the request passes the
// multiply, add and finish steps in turn before m_tvalid rises. A modulo
// request with a nonzero divisor adds a pass through the restoring remainder
// unit, 31 quotient bits at one per cycle and then the hand-over of the
// remainder. A seed load goes from acceptance straight to the finish step.
// The core takes one request at a time and holds s_tready low while a request
// is in progress; it accepts the next request as soon as the previous result
// sits in the output register.
// If the receiver stalls, the result is held in the output register and a
// following result waits in the finish step until that register is free.
// Reset clears the seed to zero and empties the output register.

module lcg_random_with_modulo_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // operand
    input  logic [1:0]  s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // number
    output logic [0:0]  m_tuser    // divide_error
);
    import lcgrm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ADD  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [31:0] seed_reg, seed_next;
    logic [31:0] prod_reg, prod_next;
    logic [1:0]  func_reg, func_next;
    logic [31:0] opnd_reg, opnd_next;
    logic [31:0] res_reg, res_next;
    logic        err_reg, err_next;
    logic        mvalid_reg, mvalid_next;
    logic [31:0] mdata_reg, mdata_next;
    logic        merr_reg, merr_next;

    logic        div_start;
    logic [31:0] div_rem;
    logic [31:0] new_seed;
    div_status_t div_status;

    assign new_seed = prod_reg + LCG_ADD;

    lcgrm_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (new_seed[30:0]),
        .divisor   (opnd_reg),
        .remainder (div_rem),
        .status    (div_status)
    );

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next  = state_reg;
        seed_next   = seed_reg;
        prod_next   = prod_reg;
        func_next   = func_reg;
        opnd_next   = opnd_reg;
        res_next    = res_reg;
        err_next    = err_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        merr_next   = merr_reg;
        div_start   = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next = s_tuser;
                    opnd_next = s_tdata;
                    if (s_tuser == FUNC_LOAD) begin
                        seed_next  = s_tdata;
                        res_next   = s_tdata;
                        err_next   = 1'b0;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = seed_reg * LCG_MUL;
                state_next = ST_ADD;
            end
            ST_ADD: begin
                seed_next  = new_seed;
                err_next   = 1'b0;
                state_next = ST_FIN;
                unique case (func_reg)
                    FUNC_RAW:      res_next = new_seed;
                    FUNC_FRACTION: res_next = new_seed & FRAC23_MASK;
                    FUNC_MODULO: begin
                        if (opnd_reg == '0) begin
                            res_next = '0;
                            err_next = 1'b1;
                        end else begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                    default:       res_next = new_seed;
                endcase
            end
            ST_DIV: begin
                if (div_status.done) begin
                    res_next   = div_rem;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!mvalid_reg || m_tready) begin
                    mvalid_next = 1'b1;
                    mdata_next  = res_reg;
                    merr_next   = err_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            seed_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            seed_reg   <= seed_next;
            mvalid_reg <= mvalid_next;
        end
        prod_reg  <= prod_next;
        func_reg  <= func_next;
        opnd_reg  <= opnd_next;
        res_reg   <= res_next;
        err_reg   <= err_next;
        mdata_reg <= mdata_next;
        merr_reg  <= merr_next;
    end

    assign m_tvalid   = mvalid_reg;
    assign m_tdata    = mdata_reg;
    assign m_tuser[0] = merr_reg;

`ifndef NO_ASSERTIONS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("divide error result carries a nonzero number");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide step");

    a_load_seed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == FUNC_LOAD)) |=>
            (seed_reg == $past(s_tdata)))
        else $error("seed load did not take the operand");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.busy |-> (state_reg == ST_DIV && !s_tready))
        else $error("divider busy while the core is not dividing");
`endif

endmodule

>>> test/lcg_random_with_modulo_core_tb.sv
// Self-checking testbench for lcg_random_with_modulo_core: raw, modulo, fraction and seed load
// requests under several idling patterns. Results are checked against a built-in predictor.
// Depends on lcgrm_pkg and the core RTL.
`timescale 1ns / 1ps

module lcg_random_with_modulo_core_tb;

    import lcgrm_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 425;
    localparam int TAIL_CYCLES     = 40;
    localparam int MAX_PRINTED     = 30;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] operand;
    } lcg_request_t;

    typedef struct packed {
        logic [31:0] number;
        logic        div_error;
    } lcg_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // operand
    logic [1:0]  s_tuser  = '0;   // func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // number
    logic [0:0]  m_tuser;         // divide_error

    lcg_request_t request_queue[$];
    lcg_result_t  awaited_results[$];
    logic [31:0]  model_seed = '0;
    logic         request_taken = 1'b0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           cycle_count = 0;
    int           error_count = 0;
    int           requests_sent = 0;
    int           results_checked = 0;
    int           zero_divisors = 0;
    int           seed_loads = 0;

    lcg_random_with_modulo_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic lcg_result_t next_lcg_result(input lcg_request_t req);
        lcg_result_t res;
        logic [31:0] low31;
        res = '0;
        if (req.func == FUNC_LOAD) begin
            model_seed = req.operand;
            res.number = req.operand;
        end else begin
            model_seed = model_seed * LCG_MUL + LCG_ADD;
            case (req.func)
                FUNC_RAW: begin
                    res.number = model_seed;
                end
                FUNC_MODULO: begin
                    low31 = model_seed & LOW31_MASK;
                    if (req.operand == 32'd0) begin
                        res.div_error = 1'b1;
                    end else begin
                        res.number = low31 % req.operand;
                    end
                end
                default: begin
                    res.number = model_seed & FRAC23_MASK;
                end
            endcase
        end
        return res;
    endfunction

    function automatic logic [31:0] random_divisor();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            return 32'd0;
        end else if (pick < 40) begin
            return 32'($urandom_range(1, 255));
        end else if (pick < 60) begin
            return 32'($urandom_range(1, 65535));
        end else if (pick < 70) begin
            return 32'h7FFF_FF00 + 32'($urandom_range(0, 511));
        end else begin
            return 32'($urandom);
        end
    endfunction

    function automatic lcg_request_t random_request();
        lcg_request_t req;
        int pick;
        pick = $urandom_range(0, 99);
        req.operand = $urandom;
        if (pick < 20) begin
            req.func = FUNC_RAW;
        end else if (pick < 65) begin
            req.func = FUNC_MODULO;
            req.operand = random_divisor();
        end else if (pick < 85) begin
            req.func = FUNC_FRACTION;
        end else begin
            req.func = FUNC_LOAD;
            if ($urandom_range(0, 9) == 0) begin
                req.operand = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            end
        end
        return req;
    endfunction

    task automatic push_request(input logic [1:0] func, input logic [31:0] operand);
        lcg_request_t req;
        req.func = func;
        req.operand = operand;
        request_queue.push_back(req);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    task automatic wait_until_drained();
        while (request_queue.size() != 0 || s_tvalid || awaited_results.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: requests and the receiver's ready change on the falling edge.
    always @(negedge aclk) begin
        lcg_request_t req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (!s_tvalid || request_taken) begin
                request_taken = 1'b0;
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.operand;
                    s_tuser  <= req.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: accepted requests feed the predictor, accepted results are checked.
    always @(posedge aclk) begin
        lcg_request_t req;
        lcg_result_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_results.size());
            $display("*** FAILED ***");
            $finish;
        end else if (aresetn) begin
            if (s_tvalid && s_tready) begin
                req.func = s_tuser;
                req.operand = s_tdata;
                if (req.func == FUNC_LOAD) begin
                    seed_loads++;
                end
                if (req.func == FUNC_MODULO && req.operand == 32'd0) begin
                    zero_divisors++;
                end
                awaited_results.push_back(next_lcg_result(req));
                requests_sent++;
                request_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result transaction", m_tdata, 32'd0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata !== want.number) begin
                        report_mismatch("number", m_tdata, want.number);
                    end
                    if (m_tuser[0] !== want.div_error) begin
                        report_mismatch("divide_error", {31'd0, m_tuser[0]},
                                        {31'd0, want.div_error});
                    end
                    results_checked++;
                end
            end
        end
    end

    initial begin
        int idle_pcts[4];
        int stall_pcts[4];
        idle_pcts  = '{0, 65, 0, 18};
        stall_pcts = '{0, 0, 65, 18};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        push_request(FUNC_RAW,      32'hFFFF_FFFF);
        push_request(FUNC_FRACTION, 32'h0000_0000);
        push_request(FUNC_MODULO,   32'd1);
        push_request(FUNC_MODULO,   32'd0);
        push_request(FUNC_MODULO,   32'hFFFF_FFFF);
        push_request(FUNC_MODULO,   32'h8000_0000);
        push_request(FUNC_MODULO,   32'h7FFF_FFFF);
        push_request(FUNC_MODULO,   32'd2);
        push_request(FUNC_MODULO,   32'd3);
        push_request(FUNC_LOAD,     32'h0000_0000);
        push_request(FUNC_RAW,      32'h5555_5555);
        push_request(FUNC_LOAD,     32'hFFFF_FFFF);
        push_request(FUNC_FRACTION, 32'hAAAA_AAAA);
        push_request(FUNC_MODULO,   32'd0);
        push_request(FUNC_LOAD,     32'h8000_0000);
        push_request(FUNC_MODULO,   32'h8000_0001);
        push_request(FUNC_LOAD,     32'h7FFF_FFFF);
        push_request(FUNC_MODULO,   32'd1000);
        push_request(FUNC_FRACTION, 32'hFFFF_FFFF);
        push_request(FUNC_LOAD,     32'h1234_5678);
        push_request(FUNC_RAW,      32'h0000_0000);
        wait_until_drained();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                request_queue.push_back(random_request());
            end
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Checked %0d results from %0d requests, %0d of them zero-divisor modulo", 
                 results_checked, requests_sent, zero_divisors);
        $display("and %0d seed loads, with idle and stall patterns on both sides.", seed_loads);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never arrived.", error_count,
                     awaited_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
